### rtl/spp_pkg.sv
// Shared types and constants for the star-shaped polygon point test.
// No dependencies; used by the front, queue, back end and top level.
package spp_pkg;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_POLAR = 2'd1;
   localparam logic [1:0] MODE_CART  = 2'd2;
   localparam logic [1:0] MODE_QUERY = 2'd3;

   localparam logic REG_CENTER_X = 1'b0;
   localparam logic REG_CENTER_Y = 1'b1;

   localparam int CORDIC_STEPS = 16;
   localparam int SQRT_STEPS   = 17;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic [16:0]        radius;
      logic [15:0]        angle;
      logic               at_center;
   } cmd_type;

   function automatic logic [15:0] ang_tab(input logic [3:0] i);
      logic [15:0] v;
      case (i)
         4'd0:    v = 16'd8192;
         4'd1:    v = 16'd4836;
         4'd2:    v = 16'd2555;
         4'd3:    v = 16'd1297;
         4'd4:    v = 16'd651;
         4'd5:    v = 16'd326;
         4'd6:    v = 16'd163;
         4'd7:    v = 16'd81;
         4'd8:    v = 16'd41;
         4'd9:    v = 16'd20;
         4'd10:   v = 16'd10;
         4'd11:   v = 16'd5;
         4'd12:   v = 16'd3;
         4'd13:   v = 16'd1;
         4'd14:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/spp_if.sv
// Request and response channel interfaces of the polygon point test.
// No dependencies.
interface spp_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [16:0]        vertex_radius;
   logic [15:0]        vertex_angle;
   modport source (output valid, mode, pos_x, pos_y, vertex_radius, vertex_angle,
                   input ready);
   modport sink   (input valid, mode, pos_x, pos_y, vertex_radius, vertex_angle,
                   output ready);
endinterface

interface spp_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_inside;
   logic       query_valid;
   logic [5:0] wedge_index;
   logic [6:0] vertex_total;
   logic       table_full;
   modport source (output valid, is_inside, query_valid, wedge_index, vertex_total,
                   table_full, input ready);
   modport sink   (input valid, is_inside, query_valid, wedge_index, vertex_total,
                   table_full, output ready);
endinterface

### rtl/spp_front.sv
// Front end: takes requests, forms centre offsets and classifies them.
// Depends on spp_pkg and spp_req_if.
module spp_front (
   spp_req_if.sink            req,
   input  logic signed [15:0] center_x,
   input  logic signed [15:0] center_y,
   input  logic               q_full,
   output logic               q_push,
   output spp_pkg::cmd_type   q_cmd
);
   import spp_pkg::*;

   logic signed [16:0] dx;
   logic signed [16:0] dy;

   assign dx = 17'(req.pos_x) - 17'(center_x);
   assign dy = 17'(req.pos_y) - 17'(center_y);

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_cmd.mode      = req.mode;
      q_cmd.dx        = dx;
      q_cmd.dy        = dy;
      q_cmd.radius    = req.vertex_radius;
      q_cmd.angle     = req.vertex_angle;
      q_cmd.at_center = (dx == 17'sd0) && (dy == 17'sd0);
   end
endmodule

### rtl/spp_fifo.sv
// Two-entry request queue between front and back end.
// Depends on spp_pkg.
module spp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  spp_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output spp_pkg::cmd_type pop_cmd
);
   import spp_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("queue pop while empty");
   a_fill_range: assert property (@(posedge clock) disable iff (reset) fill_ff != 2'd3)
      else $error("queue fill out of range");
endmodule

### rtl/spp_back.sv
// Back end: CORDIC and square root, vertex table search, insert and edge test.
// Depends on spp_pkg and spp_rsp_if.
module spp_back #(
   parameter int MAX_VERTICES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_not_empty,
   input  spp_pkg::cmd_type q_cmd,
   output logic             q_pop,
   spp_rsp_if.source        rsp
);
   import spp_pkg::*;

   localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SQ, S_POLAR, S_SRD, S_SCHK, S_DEC, S_SHRD, S_SHWR, S_WR,
      S_ERD1, S_ERD2, S_EMUL, S_ECMP, S_OUT
   } state_type;

   state_type          state_ff;
   cmd_type            cmd_ff;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      j_ff;
   logic [IW-1:0]      w_ff;
   logic [IW-1:0]      w2_ff;
   logic               eq_ff;
   logic signed [27:0] x_ff;
   logic signed [27:0] y_ff;
   logic [15:0]        z_ff;
   logic [4:0]         it_ff;
   logic [33:0]        sq_ff;
   logic [20:0]        rem_ff;
   logic [16:0]        root_ff;
   logic [16:0]        r_ff;
   logic [15:0]        a_ff;
   logic [15:0]        a1_ff;
   logic [16:0]        r1_ff;
   logic [32:0]        p0_ff;
   logic [32:0]        p1_ff;
   logic [32:0]        p2_ff;
   logic               ok_ff;
   logic               inside_ff;
   logic               qvalid_ff;
   logic               full_ff;

   logic               out_valid_ff;
   logic               out_inside_ff;
   logic               out_qvalid_ff;
   logic [5:0]         out_wedge_ff;
   logic [6:0]         out_total_ff;
   logic               out_full_ff;

   logic [32:0]        mem [MAX_VERTICES];
   logic [32:0]        rd_ff;
   logic [IW-1:0]      mem_raddr;
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   logic [32:0]        mem_wdata;

   logic [15:0]        rd_ang;
   logic [16:0]        rd_rad;
   logic signed [27:0] xs;
   logic signed [27:0] ys;
   logic [20:0]        rem_sh;
   logic [20:0]        trial;
   logic [CW-1:0]      w_full;
   logic [CW-1:0]      w_next;
   logic [15:0]        da;
   logic [15:0]        off;
   logic signed [34:0] sq_sum;
   logic               out_free;
   logic               out_load;

   assign rd_ang   = rd_ff[32:17];
   assign rd_rad   = rd_ff[16:0];
   assign xs       = x_ff >>> it_ff[3:0];
   assign ys       = y_ff >>> it_ff[3:0];
   assign rem_sh   = {rem_ff[18:0], sq_ff[33:32]};
   assign trial    = {2'b00, root_ff, 2'b01};
   assign w_full   = ((idx_ff == '0) || (idx_ff == count_ff)) ? count_ff - 1'b1
                                                              : idx_ff - 1'b1;
   assign w_next   = (CW'(w_ff) + 1'b1 < count_ff) ? CW'(w_ff) + 1'b1 : '0;
   assign da       = rd_ang - a1_ff;
   assign off      = a_ff - a1_ff;
   assign sq_sum   = 35'(cmd_ff.dx) * 35'(cmd_ff.dx) + 35'(cmd_ff.dy) * 35'(cmd_ff.dy);
   assign out_free = !out_valid_ff || rsp.ready;
   assign out_load = (state_ff == S_OUT) && out_free;

   assign q_pop = (state_ff == S_IDLE) && q_not_empty;

   always_comb begin
      mem_raddr = idx_ff[IW-1:0];
      case (state_ff)
         S_SHRD:  mem_raddr = IW'(j_ff - 1'b1);
         S_ERD1:  mem_raddr = w_ff;
         S_ERD2:  mem_raddr = w2_ff;
         default: mem_raddr = idx_ff[IW-1:0];
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = idx_ff[IW-1:0];
      mem_wdata = {a_ff, r_ff};
      case (state_ff)
         S_DEC: mem_we = (cmd_ff.mode != MODE_QUERY) && eq_ff;
         S_SHWR: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff[IW-1:0];
            mem_wdata = rd_ff;
         end
         S_WR:    mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp.ready && !out_load) out_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_not_empty) begin
                  cmd_ff    <= q_cmd;
                  inside_ff <= 1'b0;
                  qvalid_ff <= 1'b0;
                  full_ff   <= 1'b0;
                  w_ff      <= '0;
                  idx_ff    <= '0;
                  eq_ff     <= 1'b0;
                  r_ff      <= q_cmd.radius;
                  a_ff      <= q_cmd.angle;
                  case (q_cmd.mode)
                     MODE_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= S_OUT;
                     end
                     MODE_POLAR: state_ff <= S_SRD;
                     default: begin
                        if (q_cmd.at_center ||
                            (q_cmd.mode == MODE_QUERY && count_ff < CW'(3)))
                           state_ff <= S_OUT;
                        else
                           state_ff <= S_SQ;
                     end
                  endcase
               end
            end
            S_SQ: begin
               sq_ff   <= sq_sum[33:0];
               rem_ff  <= '0;
               root_ff <= '0;
               it_ff   <= '0;
               if (cmd_ff.dx[16]) begin
                  x_ff <= -{{3{cmd_ff.dx[16]}}, cmd_ff.dx, 8'h00};
                  y_ff <= -{{3{cmd_ff.dy[16]}}, cmd_ff.dy, 8'h00};
                  z_ff <= 16'h8000;
               end else begin
                  x_ff <= {{3{cmd_ff.dx[16]}}, cmd_ff.dx, 8'h00};
                  y_ff <= {{3{cmd_ff.dy[16]}}, cmd_ff.dy, 8'h00};
                  z_ff <= '0;
               end
               state_ff <= S_POLAR;
            end
            S_POLAR: begin
               sq_ff <= {sq_ff[31:0], 2'b00};
               if (rem_sh >= trial) begin
                  rem_ff  <= rem_sh - trial;
                  root_ff <= {root_ff[15:0], 1'b1};
               end else begin
                  rem_ff  <= rem_sh;
                  root_ff <= {root_ff[15:0], 1'b0};
               end
               if (it_ff < 5'(CORDIC_STEPS)) begin
                  if (!y_ff[27]) begin
                     x_ff <= x_ff + ys;
                     y_ff <= y_ff - xs;
                     z_ff <= z_ff + ang_tab(it_ff[3:0]);
                  end else begin
                     x_ff <= x_ff - ys;
                     y_ff <= y_ff + xs;
                     z_ff <= z_ff - ang_tab(it_ff[3:0]);
                  end
               end
               it_ff <= it_ff + 1'b1;
               if (it_ff == 5'(SQRT_STEPS - 1)) begin
                  r_ff     <= (rem_sh >= trial) ? {root_ff[15:0], 1'b1}
                                                : {root_ff[15:0], 1'b0};
                  a_ff     <= z_ff;
                  state_ff <= S_SRD;
               end
            end
            S_SRD: begin
               if (idx_ff == count_ff) begin
                  eq_ff    <= 1'b0;
                  state_ff <= S_DEC;
               end else begin
                  state_ff <= S_SCHK;
               end
            end
            S_SCHK: begin
               if ((cmd_ff.mode == MODE_QUERY) ? (rd_ang > a_ff) : (rd_ang >= a_ff)) begin
                  eq_ff    <= (rd_ang == a_ff);
                  state_ff <= S_DEC;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_SRD;
               end
            end
            S_DEC: begin
               if (cmd_ff.mode == MODE_QUERY) begin
                  w_ff     <= w_full[IW-1:0];
                  state_ff <= S_ERD1;
               end else if (eq_ff) begin
                  state_ff <= S_OUT;
               end else if (count_ff >= CW'(MAX_VERTICES)) begin
                  full_ff  <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  j_ff     <= count_ff;
                  state_ff <= S_SHRD;
               end
            end
            S_SHRD: begin
               state_ff <= (j_ff == idx_ff) ? S_WR : S_SHWR;
            end
            S_SHWR: begin
               j_ff     <= j_ff - 1'b1;
               state_ff <= S_SHRD;
            end
            S_WR: begin
               count_ff <= count_ff + 1'b1;
               state_ff <= S_OUT;
            end
            S_ERD1: begin
               w2_ff    <= w_next[IW-1:0];
               state_ff <= S_ERD2;
            end
            S_ERD2: begin
               a1_ff    <= rd_ang;
               r1_ff    <= rd_rad;
               state_ff <= S_EMUL;
            end
            S_EMUL: begin
               p0_ff    <= r_ff * da;
               p1_ff    <= r1_ff * (da - off);
               p2_ff    <= rd_rad * off;
               ok_ff    <= (da != '0) && (off < da) && !(r1_ff == '0 && rd_rad == '0);
               state_ff <= S_ECMP;
            end
            S_ECMP: begin
               qvalid_ff <= ok_ff;
               inside_ff <= ok_ff && (34'(p0_ff) < 34'(p1_ff) + 34'(p2_ff));
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  out_valid_ff  <= 1'b1;
                  out_inside_ff <= inside_ff;
                  out_qvalid_ff <= qvalid_ff;
                  out_wedge_ff  <= 6'(w_ff);
                  out_total_ff  <= 7'(count_ff);
                  out_full_ff   <= full_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.is_inside    = out_inside_ff;
   assign rsp.query_valid  = out_qvalid_ff;
   assign rsp.wedge_index  = out_wedge_ff;
   assign rsp.vertex_total = out_total_ff;
   assign rsp.table_full   = out_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_VERTICES))
      else $error("vertex count above table size");
   a_inside_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.is_inside) |-> rsp.query_valid)
      else $error("inside reported without valid wedge");
   a_shift_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHRD && j_ff != idx_ff) |=> state_ff == S_SHWR)
      else $error("insert shift skipped a move");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE)
      else $error("popped request not taken up");
endmodule

### rtl/star_polygon_point_test.sv
// Top level of the star-shaped polygon point test: APB registers, front,
// queue and back end. Depends on spp_pkg, spp_if, spp_front, spp_fifo, spp_back.
//
//   channel    dir  handshake            carries
//   req_chan   in   valid/ready          mode, pos_x, pos_y, vertex_radius, vertex_angle
//   rsp_chan   out  valid/ready          is_inside, query_valid, wedge_index, ...
//   csr_*      in   APB psel/penable     center_x @0x0, center_y @0x4
//
// Clear empties the table. A polar add scans the table for its place and shifts the
// entries above it up; a Cartesian add first runs the square root (17 steps) alongside
// the CORDIC. A query scans the entries in the table memory, then tests one wedge edge.
// Reset is synchronous and empties the table; table contents need no clearing.
// A two-entry queue lets the front keep taking requests while the back stalls.
module star_polygon_point_test #(
   parameter int MAX_VERTICES = 64
) (
   input  logic        clock,
   input  logic        reset,
   spp_req_if.sink     req_chan,
   spp_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import spp_pkg::*;

   logic signed [15:0] center_x_ff;
   logic signed [15:0] center_y_ff;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_not_empty;
   cmd_type            push_cmd;
   cmd_type            pop_cmd;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CENTER_Y) ? {16'h0000, center_y_ff}
                                                      : {16'h0000, center_x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_CENTER_X) center_x_ff <= csr_pwdata[15:0];
         else                              center_y_ff <= csr_pwdata[15:0];
      end
   end

   spp_front u_front (
      .req      (req_chan),
      .center_x (center_x_ff),
      .center_y (center_y_ff),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   spp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (pop_cmd)
   );

   spp_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_cmd       (pop_cmd),
      .q_pop       (q_pop),
      .rsp         (rsp_chan)
   );
endmodule
